// ===== hw/rtl/ccd_pkg.sv =====
// Shared types, constants and decode helpers for the caption pair decoder.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package ccd_pkg;

    localparam int ROWS              = 15;
    localparam int COLUMNS_DEFAULT   = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] NO_PAIR      = 16'hFFFF;
    localparam logic [7:0]  ROW_END_CHAR = 8'h0A;

    // Miscellaneous control codes, second byte of a 0x14 pair.
    localparam logic [6:0] CMD_RCL = 7'h20;
    localparam logic [6:0] CMD_BS  = 7'h21;
    localparam logic [6:0] CMD_FON = 7'h28;
    localparam logic [6:0] CMD_RDC = 7'h29;
    localparam logic [6:0] CMD_EDM = 7'h2C;
    localparam logic [6:0] CMD_CR  = 7'h2D;
    localparam logic [6:0] CMD_EOC = 7'h2F;

    localparam logic [6:0] TAB_1 = 7'h21;
    localparam logic [6:0] TAB_2 = 7'h22;
    localparam logic [6:0] TAB_3 = 7'h23;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CHAR,
        OP_PAC,
        OP_MIDROW,
        OP_BACKSPACE,
        OP_CLOSE,
        OP_ERASE_MEM,
        OP_CR,
        OP_FLASH,
        OP_TAB
    } t_op;

    typedef enum logic [1:0] {
        KIND_CELL,
        KIND_ROW_END,
        KIND_OPEN,
        KIND_CLOSE
    } t_kind;

    // Classified request handed from the front to the back.
    typedef struct packed {
        t_op         op;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
        logic        has_ch1;
        logic [3:0]  row;
        logic [4:0]  col;
        logic [2:0]  color;
        logic [2:0]  attr;
        logic [1:0]  tab;
        logic [31:0] stamp_ms;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  row;
        logic [5:0]  column;
        logic [7:0]  char_code;
        logic [2:0]  attribute;
        logic [2:0]  color;
        logic [31:0] open_time;
        logic        last;
    } t_res;

    // Caption row selected by the PAC row index; slot 1 never occurs.
    function automatic logic [3:0] pac_row(input logic [3:0] idx);
        logic [3:0] r;
        case (idx)
            4'd0:    r = 4'd10;
            4'd1:    r = 4'd0;
            4'd2:    r = 4'd0;
            4'd3:    r = 4'd1;
            4'd4:    r = 4'd2;
            4'd5:    r = 4'd3;
            4'd6:    r = 4'd11;
            4'd7:    r = 4'd12;
            4'd8:    r = 4'd13;
            4'd9:    r = 4'd14;
            4'd10:   r = 4'd4;
            4'd11:   r = 4'd5;
            4'd12:   r = 4'd6;
            4'd13:   r = 4'd7;
            4'd14:   r = 4'd8;
            4'd15:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Attribute bits of a style index: bit0 italic, bit1 underline.
    function automatic logic [2:0] font_bits(input logic [3:0] i);
        logic it;
        it = (i == 4'd14) || (i == 4'd15);
        return {1'b0, i[0], it};
    endfunction

endpackage

// ===== hw/rtl/ccd_front.sv =====
// Front end: strips parity, drops padding and repeated control pairs, and
// classifies each pair into a request for the back end. Depends on ccd_pkg.
module ccd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_code,
    input  logic [31:0]   i_time,
    input  logic          i_full,
    output logic          o_push,
    output ccd_pkg::t_cmd o_cmd
);
    import ccd_pkg::*;

    logic [15:0] r_prev_pair;
    logic [15:0] n_prev_pair;
    logic [6:0]  hi;
    logic [6:0]  lo;
    logic [6:0]  h;
    logic [15:0] pair;
    logic [4:0]  pi;
    t_cmd        cmd;

    assign hi   = i_code[14:8];
    assign lo   = i_code[6:0];
    assign pair = {1'b0, hi, 1'b0, lo};
    assign pi   = lo[4:0];

    always_comb begin
        h = (hi >= 7'h18) ? hi - 7'h08 : hi;
        if (h == 7'h15 && lo >= 7'h20 && lo <= 7'h2F) begin
            h = 7'h14;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.stamp_ms = i_time;
        // PAC fields are filled in always; only a PAC request uses them.
        cmd.row   = pac_row({h[2:0], lo[5]});
        cmd.col   = pi[4] ? {pi[3:1], 2'b00} : 5'd0;
        cmd.color = (pi < 5'd14) ? pi[3:1] : 3'd0;
        cmd.attr  = pi[4] ? {1'b0, pi[0], 1'b0} : font_bits(pi[3:0]);
        n_prev_pair = r_prev_pair;

        if (hi == 7'h00 && lo == 7'h00) begin
            n_prev_pair = r_prev_pair;
        end else if (hi >= 7'h10 && hi <= 7'h1F) begin
            if (r_prev_pair == pair) begin
                n_prev_pair = NO_PAIR;
            end else begin
                n_prev_pair = pair;
                case (h)
                    7'h10: begin
                        if (lo >= 7'h40 && lo <= 7'h5F) cmd.op = OP_PAC;
                    end
                    7'h11: begin
                        if (lo >= 7'h20 && lo <= 7'h2F) begin
                            cmd.op    = OP_MIDROW;
                            cmd.color = (lo[3:0] < 4'd14) ? lo[3:1] : 3'd0;
                            cmd.attr  = font_bits(lo[3:0]);
                        end else if (lo >= 7'h30 && lo <= 7'h3F) begin
                            cmd.op  = OP_CHAR;
                            cmd.ch0 = {1'b0, lo} + 8'h50;
                        end else if (lo >= 7'h40) begin
                            cmd.op = OP_PAC;
                        end
                    end
                    7'h12, 7'h13: begin
                        if (lo >= 7'h20 && lo <= 7'h3F) begin
                            cmd.op  = OP_CHAR;
                            cmd.ch0 = {1'b0, lo} + ((h == 7'h12) ? 8'h70 : 8'h90);
                        end else if (lo >= 7'h40) begin
                            cmd.op = OP_PAC;
                        end
                    end
                    7'h14, 7'h15: begin
                        if (h == 7'h14 && lo >= 7'h20 && lo <= 7'h2F) begin
                            case (lo)
                                CMD_BS:                   cmd.op = OP_BACKSPACE;
                                CMD_RCL, CMD_RDC, CMD_EOC: cmd.op = OP_CLOSE;
                                CMD_EDM:                  cmd.op = OP_ERASE_MEM;
                                CMD_CR:                   cmd.op = OP_CR;
                                CMD_FON:                  cmd.op = OP_FLASH;
                                default:                  cmd.op = OP_NONE;
                            endcase
                        end else if (lo >= 7'h40) begin
                            cmd.op = OP_PAC;
                        end
                    end
                    7'h16: begin
                        if (lo >= 7'h40) cmd.op = OP_PAC;
                    end
                    7'h17: begin
                        if (lo == TAB_1 || lo == TAB_2 || lo == TAB_3) begin
                            cmd.op  = OP_TAB;
                            cmd.tab = lo[1:0];
                        end else if (lo >= 7'h40) begin
                            cmd.op = OP_PAC;
                        end
                    end
                    default: cmd.op = OP_NONE;
                endcase
            end
        end else begin
            n_prev_pair = NO_PAIR;
            if (hi >= 7'h20) begin
                cmd.op      = OP_CHAR;
                cmd.ch0     = {1'b0, hi};
                cmd.ch1     = {1'b0, lo};
                cmd.has_ch1 = (lo >= 7'h20);
                n_prev_pair = '0;
            end
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && (cmd.op != OP_NONE);
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pair <= '0;
        end else if (i_valid && !i_full) begin
            r_prev_pair <= n_prev_pair;
        end
    end

endmodule

// ===== hw/rtl/ccd_fifo.sv =====
// Short request queue between the front and back ends.
// Register-based, one write and one read per cycle; no write is taken while full and no read while empty; uses ccd_pkg.
module ccd_fifo #(
    parameter int DEPTH = ccd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccd_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output ccd_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import ccd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count exceeds its depth");

endmodule

// ===== hw/rtl/ccd_back.sv =====
// Back end: holds cursor, pen and event state, carries out one request per
// pop and serializes up to two results through an output register. Uses ccd_pkg.
module ccd_back #(
    parameter int COLUMNS = ccd_pkg::COLUMNS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ccd_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output ccd_pkg::t_res o_res
);
    import ccd_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam logic [CW-1:0] CMAX = CW'(COLUMNS - 1);

    logic [3:0]    r_row,    n_row;
    logic [CW-1:0] r_col,    n_col;
    logic [2:0]    r_color,  n_color;
    logic [2:0]    r_attr,   n_attr;
    logic          r_exists, n_exists;
    logic          r_open,   n_open;
    t_res          r_out;
    logic          r_out_v;
    t_res          r_pend;
    logic          r_pend_v;

    t_res          res [2];
    logic [1:0]    cnt;
    logic [CW-1:0] ncol;
    logic [CW:0]   tab_sum;
    logic          take;
    logic          pop;
    t_cmd          c;

    function automatic t_res mk(input t_kind k, input logic [3:0] r, input logic [5:0] col,
                                input logic [7:0] ch, input logic [2:0] at,
                                input logic [2:0] co, input logic [31:0] t);
        t_res x;
        x.kind      = k;
        x.row       = r;
        x.column    = col;
        x.char_code = ch;
        x.attribute = at;
        x.color     = co;
        x.open_time = t;
        x.last      = 1'b0;
        return x;
    endfunction

    assign c    = i_q_cmd;
    assign take = r_out_v && i_ready;
    assign pop  = i_q_valid && !r_pend_v && (!r_out_v || i_ready);

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_color  = r_color;
        n_attr   = r_attr;
        n_exists = r_exists;
        n_open   = r_open;
        res[0]   = '0;
        res[1]   = '0;
        cnt      = 2'd0;
        ncol     = (6'(c.col) > 6'(CMAX)) ? CMAX : CW'(c.col);
        tab_sum  = {1'b0, r_col} + (CW+1)'(c.tab);

        case (c.op)
            OP_CHAR: begin
                if (r_exists && r_open) begin
                    res[0] = mk(KIND_CELL, n_row, 6'(n_col), c.ch0, n_attr, n_color, '0);
                    cnt    = 2'd1;
                    if (n_col < CMAX) n_col = n_col + CW'(1);
                    if (c.has_ch1) begin
                        res[1] = mk(KIND_CELL, n_row, 6'(n_col), c.ch1, n_attr, n_color, '0);
                        cnt    = 2'd2;
                        if (n_col < CMAX) n_col = n_col + CW'(1);
                    end
                end
            end
            OP_PAC: begin
                if ((c.row != r_row && 5'(c.row) != 5'(r_row) + 5'd1) ||
                    c.color != r_color || !r_exists || !r_open) begin
                    // A new caption line: close the open event and open a fresh one.
                    if (r_exists && r_open) begin
                        res[cnt[0]] = mk(KIND_CLOSE, '0, '0, '0, '0, '0, '0);
                        cnt         = cnt + 2'd1;
                    end
                    res[cnt[0]] = mk(KIND_OPEN, '0, '0, '0, '0, '0, c.stamp_ms);
                    cnt         = cnt + 2'd1;
                    n_row    = c.row;
                    n_col    = ncol;
                    n_color  = c.color;
                    n_exists = 1'b1;
                    n_open   = 1'b1;
                    n_attr   = c.attr;
                end else begin
                    if (6'(ncol) != 6'(r_col) && 6'(ncol) != 6'(r_col) + 6'd1 &&
                        5'(c.row) == 5'(r_row) + 5'd1) begin
                        res[0] = mk(KIND_ROW_END, r_row, 6'(COLUMNS), ROW_END_CHAR,
                                    r_attr, r_color, '0);
                        cnt    = 2'd1;
                        n_row  = c.row;
                        n_col  = ncol;
                    end
                    n_attr = c.attr | (r_attr & 3'b100);
                end
            end
            OP_MIDROW: begin
                n_color = c.color;
                n_attr  = c.attr;
            end
            OP_BACKSPACE: begin
                if (r_exists && r_col != '0) begin
                    n_col  = r_col - CW'(1);
                    res[0] = mk(KIND_CELL, r_row, 6'(n_col), 8'h00, r_attr, r_color, '0);
                    cnt    = 2'd1;
                end
            end
            OP_CLOSE, OP_ERASE_MEM: begin
                if (r_exists && r_open) begin
                    n_open = 1'b0;
                    res[0] = mk(KIND_CLOSE, '0, '0, '0, '0, '0, '0);
                    cnt    = 2'd1;
                end
                if (c.op == OP_ERASE_MEM) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_color = '0;
                    n_attr  = '0;
                end
            end
            OP_CR: begin
                n_col = '0;
                if (r_row < 4'(ROWS - 1)) n_row = r_row + 4'd1;
            end
            OP_FLASH: begin
                n_attr = r_attr | 3'b100;
            end
            OP_TAB: begin
                n_col = (tab_sum > {1'b0, CMAX}) ? CMAX : tab_sum[CW-1:0];
            end
            default: begin
                n_row = r_row;
            end
        endcase

        if (cnt == 2'd1) res[0].last = 1'b1;
        if (cnt == 2'd2) res[1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_color  <= '0;
            r_attr   <= '0;
            r_exists <= 1'b0;
            r_open   <= 1'b0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (r_pend_v && (!r_out_v || i_ready)) begin
                r_out    <= r_pend;
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (pop) begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_color  <= n_color;
                r_attr   <= n_attr;
                r_exists <= n_exists;
                r_open   <= n_open;
                if (cnt != 2'd0) begin
                    r_out   <= res[0];
                    r_out_v <= 1'b1;
                end else if (take) begin
                    r_out_v <= 1'b0;
                end
                if (cnt == 2'd2) begin
                    r_pend   <= res[1];
                    r_pend_v <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_q_pop = pop;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_out_v)
        else $error("second result held while the output register is empty");

    a_open_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> r_exists)
        else $error("event marked open without an existing event");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= CMAX) && (r_row < 4'(ROWS)))
        else $error("cursor left the caption grid");

endmodule

// ===== hw/rtl/cea608_caption_pair_decoder.sv =====
// Top level of the caption pair decoder: stream ports, packing of the payload,
// and the front, queue and back instances. Depends on ccd_pkg, ccd_front,
// ccd_fifo and ccd_back.
//
// Usage:
//   The slave channel (i_s_*) takes one raw byte pair per request together with
//   the cue time of its line. The master channel (o_m_*) returns zero, one or
//   two result requests per pair; tlast marks the final result of a pair.
//   A pair that causes no result (padding, a dropped repeat, a style change,
//   a cursor move) is consumed silently.
//   The first result of a pair reaches the master side through the queue register
//   and then the output register. The back end takes a new queued pair every cycle
//   while the output register is free or being taken; a pair with two results holds
//   the next pair back while its second result waits in the one-deep holding
//   register behind the single output register.
//   The front end classifies pairs and tracks the previous control pair; a
//   short queue lets it keep taking pairs while the back end drains results.
//   When the receiver stalls, the output register holds its result, the queue
//   fills, and then o_s_tready drops until room returns; nothing is lost.
//   Reset (synchronous, active low) clears the cursor to row 0 column 0, the
//   pen to white without attributes, the event flags, the previous-pair
//   register, the queue and the output valid flags. No clearing pass is needed.
module cea608_caption_pair_decoder #(
    parameter int COLUMNS     = ccd_pkg::COLUMNS_DEFAULT,
    parameter int QUEUE_DEPTH = ccd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] code word, [47:16] cue time in ms
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [1:0] kind, [5:2] row, [11:6] column,
                                     // [19:12] char_code, [22:20] attribute,
                                     // [25:23] color, [57:26] open_time_ms, zeros above
    output logic        o_m_tlast
);
    import ccd_pkg::*;

    t_cmd push_cmd;
    t_cmd q_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_res res;

    ccd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_code  (i_s_tdata[15:0]),
        .i_time  (i_s_tdata[47:16]),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ccd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    ccd_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (res)
    );

    assign o_m_tdata = {6'b0, res.open_time, res.color, res.attribute, res.char_code,
                        res.column, res.row, res.kind};
    assign o_m_tlast = res.last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cea608_caption_pair_decoder: directed caption sequences, then
// random byte-pair streams under four idling patterns. Depends on ccd_pkg and the decoder RTL.
module tb_top;

    import ccd_pkg::*;

    // First bytes of the control pairs on channel 1; channel 2 adds CC_CH2.
    localparam logic [6:0] CC_PAC_ONLY = 7'h10;
    localparam logic [6:0] CC_SPECIAL  = 7'h11;
    localparam logic [6:0] CC_EXT_A    = 7'h12;
    localparam logic [6:0] CC_EXT_B    = 7'h13;
    localparam logic [6:0] CC_MISC     = 7'h14;
    localparam logic [6:0] CC_MISC_ALT = 7'h15;
    localparam logic [6:0] CC_PAC_16   = 7'h16;
    localparam logic [6:0] CC_TAB      = 7'h17;
    localparam logic [6:0] CC_LAST     = 7'h1F;
    localparam logic [6:0] CC_CH2      = 7'h08;

    localparam int         NCOLS    = COLUMNS_DEFAULT;
    localparam logic [3:0] LAST_ROW = 4'(ROWS - 1);
    // Caption row per PAC row index, index 0 in the lowest nibble.
    localparam logic [63:0] PAC_ROWS = {4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd14, 4'd13,
                                        4'd12, 4'd11, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd10};
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;      // [15:0] code word, [47:16] cue time in ms
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;           // [1:0] kind, [5:2] row, [11:6] column, [19:12] char_code,
                                      // [22:20] attribute, [25:23] color, [57:26] open_time_ms
    logic        o_m_tlast;

    cea608_caption_pair_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decoder state as the predictor sees it.
    logic [3:0]  cur_row;
    logic [4:0]  cur_col;
    logic [2:0]  pen_color;
    logic [2:0]  pen_attr;
    logic        ev_exists;
    logic        ev_open;
    logic [15:0] prev_pair;

    // Results of the pair being decoded, then the queue of results still owed by the block.
    t_res pair_results [4];
    int   n_pair_results;
    t_res pending_results [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // Caption decode predictor
    // ------------------------------------------------------------------

    task automatic add_result(input t_kind k, input logic [3:0] r, input logic [5:0] c,
                              input logic [7:0] ch, input logic [2:0] a, input logic [2:0] col,
                              input logic [31:0] t);
        t_res e;
        e.kind = k;
        e.row = r;
        e.column = c;
        e.char_code = ch;
        e.attribute = a;
        e.color = col;
        e.open_time = t;
        e.last = 1'b0;
        pair_results[n_pair_results] = e;
        n_pair_results++;
    endtask

    task automatic close_caption();
        if (ev_exists && ev_open) begin
            ev_open = 1'b0;
            add_result(KIND_CLOSE, '0, '0, '0, '0, '0, '0);
        end
    endtask

    // A character only lands while an event is open; the cursor sticks at the last column.
    task automatic put_char(input logic [7:0] ch);
        if (ev_exists && ev_open) begin
            add_result(KIND_CELL, cur_row, {1'b0, cur_col}, ch, pen_attr, pen_color, '0);
            if (int'(cur_col) < NCOLS - 1)
                cur_col++;
        end
    endtask

    function automatic logic [2:0] pen_style(input logic [3:0] idx);
        return {1'b0, idx[0], (idx == 4'd14 || idx == 4'd15)};
    endfunction

    task automatic advance_tab(input int k);
        int c;
        c = int'(cur_col) + k;
        if (c > NCOLS - 1)
            c = NCOLS - 1;
        cur_col = 5'(c);
    endtask

    task automatic apply_pac(input logic [6:0] h, input logic [6:0] lo, input logic [31:0] cue);
        int         idx;
        int         ii;
        int         c;
        logic [3:0] nr;
        logic [4:0] ncol;
        logic [2:0] ncolor;
        logic [2:0] fb;
        idx = {h[2:0], lo[5]};
        ii = lo[4:0];
        nr = PAC_ROWS[idx*4 +: 4];
        c = (ii >= 16) ? ((ii - 16) >> 1) * 4 : 0;
        if (c > NCOLS - 1)
            c = NCOLS - 1;
        ncol = 5'(c);
        ncolor = (ii < 14) ? 3'(ii >> 1) : 3'd0;
        fb = (ii < 16) ? pen_style(lo[3:0]) : {1'b0, lo[0], 1'b0};

        // A jump to an unrelated row, a color change or no open event starts a new event.
        if ((nr != cur_row && int'(nr) != int'(cur_row) + 1) || ncolor != pen_color ||
            !ev_exists || !ev_open) begin
            close_caption();
            cur_row = nr;
            cur_col = ncol;
            pen_color = ncolor;
            pen_attr = '0;
            ev_exists = 1'b1;
            ev_open = 1'b1;
            add_result(KIND_OPEN, '0, '0, '0, '0, '0, cue);
        end
        // Moving down one row to a new indent ends the current row.
        if (int'(ncol) != int'(cur_col) && int'(ncol) != int'(cur_col) + 1 &&
            int'(nr) == int'(cur_row) + 1) begin
            add_result(KIND_ROW_END, cur_row, 6'(NCOLS), ROW_END_CHAR, pen_attr, pen_color, '0);
            cur_row = nr;
            cur_col = ncol;
        end
        pen_attr = fb | (pen_attr & 3'b100);
    endtask

    task automatic apply_command(input logic [6:0] lo);
        case (lo)
            CMD_BS: begin
                if (ev_exists && cur_col > 0) begin
                    cur_col--;
                    add_result(KIND_CELL, cur_row, {1'b0, cur_col}, 8'h00, pen_attr,
                               pen_color, '0);
                end
            end
            CMD_RCL, CMD_RDC, CMD_EOC: close_caption();
            CMD_EDM: begin
                close_caption();
                cur_row = '0;
                cur_col = '0;
                pen_color = '0;
                pen_attr = '0;
            end
            CMD_CR: begin
                cur_col = '0;
                if (cur_row < LAST_ROW)
                    cur_row++;
            end
            CMD_FON: pen_attr = pen_attr | 3'b100;
            default: ;
        endcase
    endtask

    // Works out what one accepted pair produces and queues it for the checker.
    task automatic decode_pair(input logic [15:0] word, input logic [31:0] cue);
        logic [6:0]  hi;
        logic [6:0]  lo;
        logic [6:0]  h;
        logic [15:0] pair;
        t_res        e;
        hi = word[14:8];
        lo = word[6:0];
        pair = {1'b0, hi, 1'b0, lo};
        n_pair_results = 0;

        if (hi == '0 && lo == '0)
            return;
        if (hi >= CC_PAC_ONLY && hi <= CC_LAST) begin
            // The redundant second copy of a control pair is swallowed once.
            if (prev_pair == pair) begin
                prev_pair = NO_PAIR;
                return;
            end
            prev_pair = pair;
            h = (hi >= CC_PAC_ONLY + CC_CH2) ? hi - CC_CH2 : hi;
            if (h == CC_MISC_ALT && lo >= 7'h20 && lo <= 7'h2F)
                h = CC_MISC;
            case (h)
                CC_PAC_ONLY: begin
                    if (lo >= 7'h40 && lo <= 7'h5F)
                        apply_pac(h, lo, cue);
                end
                CC_SPECIAL: begin
                    if (lo >= 7'h20 && lo <= 7'h2F) begin
                        pen_color = (lo[3:0] < 4'd14) ? 3'(lo[3:0] >> 1) : 3'd0;
                        pen_attr = pen_style(lo[3:0]);
                    end else if (lo >= 7'h30 && lo <= 7'h3F) begin
                        put_char({1'b0, lo} + 8'h50);
                    end else if (lo >= 7'h40) begin
                        apply_pac(h, lo, cue);
                    end
                end
                CC_EXT_A, CC_EXT_B: begin
                    if (lo >= 7'h20 && lo <= 7'h3F)
                        put_char({1'b0, lo} + ((h == CC_EXT_A) ? 8'h70 : 8'h90));
                    else if (lo >= 7'h40)
                        apply_pac(h, lo, cue);
                end
                CC_MISC, CC_MISC_ALT: begin
                    if (h == CC_MISC && lo >= 7'h20 && lo <= 7'h2F)
                        apply_command(lo);
                    else if (lo >= 7'h40)
                        apply_pac(h, lo, cue);
                end
                CC_PAC_16: begin
                    if (lo >= 7'h40)
                        apply_pac(h, lo, cue);
                end
                CC_TAB: begin
                    if (lo == TAB_1)
                        advance_tab(1);
                    else if (lo == TAB_2)
                        advance_tab(2);
                    else if (lo == TAB_3)
                        advance_tab(3);
                    else if (lo >= 7'h40)
                        apply_pac(h, lo, cue);
                end
                default: ;
            endcase
        end else begin
            prev_pair = NO_PAIR;
            if (hi >= 7'h20) begin
                put_char({1'b0, hi});
                if (lo >= 7'h20)
                    put_char({1'b0, lo});
                prev_pair = '0;
            end
        end

        for (int k = 0; k < n_pair_results; k++) begin
            e = pair_results[k];
            e.last = (k == n_pair_results - 1);
            pending_results.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driving and result checking
    // ------------------------------------------------------------------

    function automatic logic [15:0] make_word(input logic [6:0] hi, input logic [6:0] lo);
        return {1'($urandom_range(1)), hi, 1'($urandom_range(1)), lo};
    endfunction

    // Sends one pair request. tvalid is left high after the handshake so back-to-back
    // requests need no second assignment in the same step; any wait must lower it first.
    task automatic send_pair(input logic [15:0] word, input logic [31:0] cue);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {cue, word};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        decode_pair(word, cue);
    endtask

    // Lowers tvalid and waits on clock edges until every outstanding result is back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_res want;
        t_res got;
        if (o_m_tvalid && i_m_tready) begin
            got.kind = t_kind'(o_m_tdata[1:0]);
            got.row = o_m_tdata[5:2];
            got.column = o_m_tdata[11:6];
            got.char_code = o_m_tdata[19:12];
            got.attribute = o_m_tdata[22:20];
            got.color = o_m_tdata[25:23];
            got.open_time = o_m_tdata[57:26];
            got.last = o_m_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                         $time, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_field("kind", want.kind, got.kind);
                if (got.row !== want.row)
                    report_field("row", want.row, got.row);
                if (got.column !== want.column)
                    report_field("column", want.column, got.column);
                if (got.char_code !== want.char_code)
                    report_field("char_code", want.char_code, got.char_code);
                if (got.attribute !== want.attribute)
                    report_field("attribute", want.attribute, got.attribute);
                if (got.color !== want.color)
                    report_field("color", want.color, got.color);
                if (got.open_time !== want.open_time)
                    report_field("open_time_ms", want.open_time, got.open_time);
                if (got.last !== want.last)
                    report_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing may come out before a caption event has been opened by a PAC.
    task automatic test_idle_decoder();
        send_pair(make_word(7'h00, 7'h00), '0);
        send_pair(make_word(7'h41, 7'h42), $urandom);
        send_pair(make_word(CC_MISC, CMD_BS), $urandom);
        send_pair(make_word(7'h05, 7'h20), $urandom);
    endtask

    // PAC placement, repeat dropping, text and special characters, styles, cursor moves.
    task automatic test_pac_and_text();
        send_pair(make_word(CC_MISC, 7'h7F), 32'hFFFF_FFFF);   // last row, indent 28, underline
        send_pair(make_word(CC_MISC, 7'h7F), $urandom);        // repeated copy is dropped
        send_pair(make_word(7'h7F, 7'h7F), $urandom);
        send_pair(make_word(7'h20, 7'h01), $urandom);          // second byte below 0x20 ignored
        send_pair(make_word(CC_SPECIAL, 7'h30), $urandom);     // lands on the last column
        send_pair(make_word(CC_EXT_A, 7'h3F), $urandom);       // cursor stays on the last column
        send_pair(make_word(CC_EXT_B, 7'h20), $urandom);
        send_pair(make_word(CC_SPECIAL, 7'h2E), $urandom);     // mid-row italics
        send_pair(make_word(CC_MISC, CMD_FON), $urandom);
        send_pair(make_word(CC_MISC, CMD_BS), $urandom);
        send_pair(make_word(CC_TAB, TAB_3), $urandom);         // saturates at the last column
        send_pair(make_word(CC_MISC + CC_CH2, CMD_CR), $urandom); // channel 2, row clamps
        send_pair(make_word(CC_PAC_ONLY, 7'h40), '0);          // new row: close then open
        send_pair(make_word(CC_EXT_B, 7'h54), $urandom);       // next row, new indent: row end
        send_pair(make_word(7'h61, 7'h62), $urandom);
        send_pair(make_word(CC_TAB, TAB_2), $urandom);
    endtask

    // Caption-closing commands and what still works on a closed event.
    task automatic test_caption_commands();
        send_pair(make_word(CC_MISC_ALT, CMD_RDC), $urandom);  // folds onto the 0x14 commands
        send_pair(make_word(CC_MISC, CMD_BS), $urandom);       // erase on a closed event
        send_pair(make_word(7'h63, 7'h64), $urandom);          // dropped, nothing open
        send_pair(make_word(CC_MISC, CMD_EDM), $urandom);
        send_pair(make_word(CC_SPECIAL, 7'h40), $urandom);
        send_pair(make_word(CC_MISC, CMD_EOC), $urandom);
        drain_results();
    endtask

    // Mostly caption-like traffic with random content; the rest is noise.
    function automatic logic [13:0] pick_pair();
        int         sel;
        logic [6:0] hi;
        logic [6:0] lo;
        sel = $urandom_range(99);
        if (sel < 25) begin
            hi = 7'($urandom_range(7'h20, 7'h7F));
            lo = ($urandom_range(9) < 8) ? 7'($urandom_range(7'h20, 7'h7F))
                                         : 7'($urandom_range(7'h1F));
        end else if (sel < 42) begin
            hi = 7'($urandom_range(CC_PAC_ONLY, CC_TAB));
            lo = 7'($urandom_range(7'h40, 7'h7F));
        end else if (sel < 50) begin
            hi = CC_SPECIAL;
            lo = 7'($urandom_range(7'h20, 7'h2F));
        end else if (sel < 60) begin
            hi = 7'($urandom_range(CC_SPECIAL, CC_EXT_B));
            lo = 7'($urandom_range(7'h20, 7'h3F));
        end else if (sel < 75) begin
            hi = $urandom_range(1) ? CC_MISC : CC_MISC_ALT;
            lo = 7'($urandom_range(7'h20, 7'h2F));
        end else if (sel < 80) begin
            hi = CC_TAB;
            lo = 7'($urandom_range(7'h20, 7'h24));
        end else if (sel < 88) begin
            hi = 7'($urandom_range(7'h0F));
            lo = 7'($urandom_range(7'h7F));
            if ($urandom_range(1))
                hi = '0;
            if (hi == '0)
                lo = '0;
        end else begin
            {hi, lo} = 14'($urandom);
        end
        if (sel >= 25 && sel < 80 && $urandom_range(1))
            hi = hi + CC_CH2;
        return {hi, lo};
    endfunction

    task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
        int          sent;
        logic [13:0] p;
        sent = 0;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < n_items) begin
            p = pick_pair();
            send_pair(make_word(p[13:7], p[6:0]), $urandom);
            sent++;
            // Control pairs usually travel twice; send the copy now and then.
            if (p[13:7] >= CC_PAC_ONLY && p[13:7] <= CC_LAST && $urandom_range(2) == 0) begin
                send_pair(make_word(p[13:7], p[6:0]), $urandom);
                sent++;
            end
        end
        // Hold the sender until every result of this phase is back.
        drain_results();
    endtask

    initial begin
        cur_row = '0;
        cur_col = '0;
        pen_color = '0;
        pen_attr = '0;
        ev_exists = 1'b0;
        ev_open = 1'b0;
        prev_pair = '0;
        n_pair_results = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_decoder();
        test_pac_and_text();
        test_caption_commands();
        test_random_traffic(255, 0, 0);
        test_random_traffic(255, 78, 0);
        test_random_traffic(255, 0, 78);
        test_random_traffic(255, 25, 25);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ccd_pkg.sv
hw/rtl/ccd_front.sv
hw/rtl/ccd_fifo.sv
hw/rtl/ccd_back.sv
hw/rtl/cea608_caption_pair_decoder.sv
tb/tb_top.sv
